[rtl/affine_matrix_inverse_core_macros.svh]
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core_macros.svh
// Assertion macros shared by the affine inverse RTL.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_CORE_MACROS_SVH

// same-cycle implication
`define AMI_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define AMI_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/ami_pkg.sv]
// ----------------------------------------------------------------------------
// ami_pkg
// Widths, types and index helpers for the affine matrix inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ami_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int IDX_W     = 4;
   localparam int MAT_DEPTH = 12;
   localparam int ADJ_DEPTH = 9;
   localparam int ADJ_W     = 66;
   localparam int ACC_W     = 100;
   localparam int NUM_W     = 114;
   localparam int DEN_W     = 98;
   localparam int Q_W       = NUM_W + 1;
   localparam int TDATA_W   = 40;
   localparam int TUSER_W   = 2;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RDA, ST_RDB, ST_MUL, ST_WAIT, ST_END, ST_DWAIT, ST_OUT, ST_SING
   } state_type;

   typedef enum logic [1:0] {
      PH_ADJ, PH_DET, PH_OUT
   } phase_type;

   function automatic logic [1:0] mod3(input logic [2:0] v);
      logic [1:0] r;
      case (v)
         3'd0, 3'd3: r = 2'd0;
         3'd1, 3'd4: r = 2'd1;
         3'd2, 3'd5: r = 2'd2;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] adj_idx(input logic [1:0] r, input logic [1:0] c);
      return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
   endfunction

endpackage

`default_nettype wire

[rtl/ami_mul.sv]
// ----------------------------------------------------------------------------
// ami_mul
// Shift-add sign-magnitude multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ami_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ami_pkg::ACC_W-1:0]  mcand,
   input  wire logic [ami_pkg::DATA_W-1:0] mplier,
   output logic                            done,
   output logic                            neg,
   output logic [ami_pkg::ACC_W-1:0]       prod_mag
);
   import ami_pkg::*;

   localparam int CNT_W = $clog2(DATA_W + 2);

   logic [ACC_W-1:0]  a_ff, p_ff;
   logic [DATA_W:0]   b_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff, neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= mcand[ACC_W-1] ? (~mcand + 1'b1) : mcand;
         b_ff   <= mplier[DATA_W-1] ? (~{1'b1, mplier} + 1'b1) : {1'b0, mplier};
         p_ff   <= '0;
         neg_ff <= mcand[ACC_W-1] ^ mplier[DATA_W-1];
      end else if (busy_ff) begin
         if (b_ff[0]) p_ff <= p_ff + a_ff;
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done     = done_ff;
   assign neg      = neg_ff;
   assign prod_mag = p_ff;

endmodule

`default_nettype wire

[rtl/ami_div.sv]
// ----------------------------------------------------------------------------
// ami_div
// Restoring divider, one quotient bit per cycle, round half away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ami_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ami_pkg::NUM_W-1:0] num_mag,
   input  wire logic [ami_pkg::DEN_W-1:0] den_mag,
   output logic                           done,
   output logic [ami_pkg::Q_W-1:0]        quot
);
   import ami_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [NUM_W-1:0] num_ff, q_ff;
   logic [Q_W-1:0]   quot_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den_mag;
         num_ff <= num_mag;
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(NUM_W)) begin
            // round: twice the remainder against the divisor
            quot_ff <= {1'b0, q_ff} + Q_W'({rem_ff, 1'b0} >= {1'b0, den_ff});
         end else begin
            rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            num_ff <= num_ff << 1;
            q_ff   <= {q_ff[NUM_W-2:0], fits};
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

[rtl/affine_matrix_inverse_core.sv]
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core
// Inverse of an affine 4x4 transform by the adjugate, signed Q16.16.
// ----------------------------------------------------------------------------
// Input words on req_*: the twelve elements of the top three rows, row-major.
// After the twelfth word the block stops taking input, computes the nine
// cofactors, the determinant and each inverse element, and presents the
// twelve results on rsp_* in row-major order with rsp_tlast on the final one.
// A zero determinant gives one result with the singular flag and tlast set.
// Loading accepts one word per cycle. Every product term goes through one
// shared shift-add multiplier (39 terms per matrix), and each result through
// a serial divider.
// Each result waits in the output register until rsp_tready; a stall simply
// holds the sequencer. Matrix and cofactor stores live in two synchronous
// memories with registered reads. Reset returns the block to loading
// with the element count at zero; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "affine_matrix_inverse_core_macros.svh"

module affine_matrix_inverse_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [ami_pkg::DATA_W-1:0]  req_tdata,   // [31:0] element_value
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ami_pkg::TDATA_W-1:0]      rsp_tdata,   // [31:0] inverse_value,
                                                         // [35:32] element_index
   output logic                             rsp_tlast,
   output logic [ami_pkg::TUSER_W-1:0]      rsp_tuser    // [0] singular, [1] saturated
);
   import ami_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff;

   logic [DATA_W-1:0] mat_mem [MAT_DEPTH];
   logic [ADJ_W-1:0]  adj_mem [ADJ_DEPTH];
   logic [DATA_W-1:0] mat_rd_ff;
   logic [ADJ_W-1:0]  adj_rd_ff;
   logic [3:0]        mat_raddr, adj_raddr;

   logic [3:0]        load_cnt_ff;
   logic [1:0]        row_ff, col_ff, term_ff;
   logic [ACC_W-1:0]  acc_ff, opa_ff, det_ff;
   logic              qneg_ff;

   logic [DATA_W-1:0] val_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              last_ff, sing_ff, sat_ff;

   logic              mul_start, mul_done, mul_neg, div_start, div_done, adj_we;
   logic [ACC_W-1:0]  prod_mag, mul_mcand, acc_mag;
   logic [DATA_W-1:0] mul_mplier;
   logic [Q_W-1:0]    quot;
   logic [NUM_W-1:0]  num_mag;
   logic              in_acc, out_acc, last_term, term_minus;
   logic [1:0]        r1, r2, c1, c2;
   logic              sat;
   logic [DATA_W-1:0] qv;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   assign r1 = mod3({1'b0, row_ff} + 3'd1);
   assign r2 = mod3({1'b0, row_ff} + 3'd2);
   assign c1 = mod3({1'b0, col_ff} + 3'd1);
   assign c2 = mod3({1'b0, col_ff} + 3'd2);

   always_comb begin
      case (phase_ff)
         PH_ADJ:  last_term = (term_ff == 2'd1);
         PH_DET:  last_term = (term_ff == 2'd2);
         PH_OUT:  last_term = (col_ff == 2'd3) ? (term_ff == 2'd2) : (term_ff == 2'd0);
         default: last_term = 1'b1;
      endcase
   end

   assign term_minus = (phase_ff == PH_ADJ) && (term_ff == 2'd1);
   assign mul_mcand  = opa_ff;
   assign mul_mplier = (phase_ff == PH_OUT && col_ff != 2'd3) ? DATA_W'(1) : mat_rd_ff;
   assign acc_mag    = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
   assign num_mag    = (col_ff == 2'd3) ? (NUM_W'(acc_mag) << FRAC_W)
                                        : (NUM_W'(acc_mag) << (2 * FRAC_W));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (in_acc && load_cnt_ff == 4'(MAT_DEPTH - 1)) state_in = ST_RDA;
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_WAIT;
         ST_WAIT:  if (mul_done) state_in = last_term ? ST_END : ST_RDA;
         ST_END: begin
            case (phase_ff)
               PH_DET:  state_in = (acc_ff == '0) ? ST_SING : ST_RDA;
               PH_OUT:  state_in = ST_DWAIT;
               default: state_in = ST_RDA;
            endcase
         end
         ST_DWAIT: if (div_done) state_in = ST_OUT;
         ST_OUT:   if (out_acc) state_in = (row_ff == 2'd2 && col_ff == 2'd3) ? ST_LOAD : ST_RDA;
         ST_SING:  if (out_acc) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // outputs and memory addresses
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      adj_we     = 1'b0;
      mat_raddr  = '0;
      adj_raddr  = '0;
      case (state_ff)
         ST_LOAD: req_tready = 1'b1;
         ST_RDA: begin
            mat_raddr = (term_ff == 2'd0) ? {c1, r1} : {c1, r2};
            case (phase_ff)
               PH_DET:  adj_raddr = adj_idx(term_ff, 2'd0);
               PH_OUT:  adj_raddr = (col_ff == 2'd3) ? adj_idx(row_ff, term_ff)
                                                     : adj_idx(row_ff, col_ff);
               default: adj_raddr = '0;
            endcase
         end
         ST_RDB: begin
            case (phase_ff)
               PH_ADJ:  mat_raddr = (term_ff == 2'd0) ? {c2, r2} : {c2, r1};
               PH_DET:  mat_raddr = {2'b00, term_ff};
               default: mat_raddr = {term_ff, 2'b11};
            endcase
         end
         ST_MUL:  mul_start = 1'b1;
         ST_END: begin
            adj_we    = (phase_ff == PH_ADJ);
            div_start = (phase_ff == PH_OUT);
         end
         ST_OUT:  rsp_tvalid = 1'b1;
         ST_SING: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_acc) mat_mem[load_cnt_ff] <= req_tdata;
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_idx(row_ff, col_ff)] <= acc_ff[ADJ_W-1:0];
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         phase_ff    <= PH_ADJ;
         load_cnt_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         term_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (in_acc) begin
            load_cnt_ff <= (load_cnt_ff == 4'(MAT_DEPTH - 1)) ? 4'd0 : load_cnt_ff + 4'd1;
            phase_ff    <= PH_ADJ;
            row_ff      <= '0;
            col_ff      <= '0;
            term_ff     <= '0;
         end
         if (state_ff == ST_WAIT && mul_done && !last_term) term_ff <= term_ff + 2'd1;
         if (state_ff == ST_END) begin
            term_ff <= '0;
            case (phase_ff)
               PH_ADJ: begin
                  if (col_ff == 2'd2) begin
                     col_ff <= '0;
                     if (row_ff == 2'd2) begin
                        row_ff   <= '0;
                        phase_ff <= PH_DET;
                     end else begin
                        row_ff <= row_ff + 2'd1;
                     end
                  end else begin
                     col_ff <= col_ff + 2'd1;
                  end
               end
               PH_DET:  phase_ff <= PH_OUT;
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_acc) begin
            term_ff <= '0;
            if (col_ff == 2'd3) begin
               col_ff <= '0;
               row_ff <= row_ff + 2'd1;
            end else begin
               col_ff <= col_ff + 2'd1;
            end
         end
      end
   end

   assign sat = qneg_ff ? (quot > Q_W'(1) << (DATA_W - 1))
                        : (quot > (Q_W'(1) << (DATA_W - 1)) - 1'b1);
   assign qv  = quot[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_RDB)
         opa_ff <= (phase_ff == PH_ADJ) ? ACC_W'(signed'(mat_rd_ff))
                                        : ACC_W'(signed'(adj_rd_ff));
      if (in_acc || state_ff == ST_END || (state_ff == ST_OUT && out_acc)) acc_ff <= '0;
      else if (state_ff == ST_WAIT && mul_done)
         acc_ff <= (mul_neg ^ term_minus) ? acc_ff - prod_mag : acc_ff + prod_mag;
      if (state_ff == ST_END && phase_ff == PH_DET) begin
         det_ff  <= acc_ff;
         val_ff  <= '0;
         idx_ff  <= '0;
         last_ff <= 1'b1;
         sing_ff <= 1'b1;
         sat_ff  <= 1'b0;
      end
      if (state_ff == ST_END && phase_ff == PH_OUT)
         qneg_ff <= (acc_ff[ACC_W-1] ^ (col_ff == 2'd3)) ^ det_ff[ACC_W-1];
      if (state_ff == ST_DWAIT && div_done) begin
         val_ff  <= sat ? (qneg_ff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}})
                        : (qneg_ff ? (~qv + 1'b1) : qv);
         idx_ff  <= {row_ff, col_ff};
         last_ff <= (row_ff == 2'd2 && col_ff == 2'd3);
         sing_ff <= 1'b0;
         sat_ff  <= sat;
      end
   end

   ami_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .mcand    (mul_mcand),
      .mplier   (mul_mplier),
      .done     (mul_done),
      .neg      (mul_neg),
      .prod_mag (prod_mag)
   );

   ami_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (num_mag),
      .den_mag ((det_ff[ACC_W-1] ? DEN_W'(~det_ff + 1'b1) : DEN_W'(det_ff))),
      .done    (div_done),
      .quot    (quot)
   );

   assign rsp_tdata = {{(TDATA_W - DATA_W - IDX_W){1'b0}}, idx_ff, val_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = {sat_ff, sing_ff};

   `AMI_ASSERT_NOW(a_no_load_while_busy, rsp_tvalid, !req_tready, "load during result")
   `AMI_ASSERT_NOW(a_singular_form, rsp_tvalid && rsp_tuser[0],
      rsp_tlast && rsp_tdata == '0 && !rsp_tuser[1], "bad singular result")
   `AMI_ASSERT_NOW(a_sat_bound, rsp_tvalid && rsp_tuser[1],
      rsp_tdata[DATA_W-1:0] == {1'b1, {(DATA_W-1){1'b0}}} ||
      rsp_tdata[DATA_W-1:0] == {1'b0, {(DATA_W-1){1'b1}}}, "saturated value off bound")
   `AMI_ASSERT_NEXT(a_load_after_last, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready, "no reload after last result")

endmodule

`default_nettype wire
